/* hw/rtl/html_strip_entity_decode_top_macros.svh */
// Assertion macros shared by the HTML strip and entity decode RTL.
`ifndef HTML_STRIP_ENTITY_DECODE_TOP_MACROS_SVH
`define HTML_STRIP_ENTITY_DECODE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HSED_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HSED_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/hsed_pkg.sv */
// Package for the HTML strip and entity decode block: types, constants, helper functions.
`default_nettype none
package hsed_pkg;

   localparam int unsigned ENTITY_SPAN = 10;
   localparam int unsigned WIN_DEPTH   = ENTITY_SPAN + 1;
   localparam int unsigned FILL_W      = $clog2(WIN_DEPTH + 1);
   localparam int unsigned EBUF_DEPTH  = 16;

   localparam logic [3:0] NL_LIMIT_RESET = 4'd2;
   localparam logic [3:0] RUN_MAX        = 4'd15;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QMARK     = 8'h3F;

   localparam logic       CSR_IDX_NL_LIMIT = 1'b0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_has_byte;
      logic       out_last;
   } rsp_type;

   typedef logic [EBUF_DEPTH-1:0][7:0] ent_buf_type;

   function automatic logic [7:0] lower_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // {valid, value}
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
      logic [4:0] r;
      r = '0;
      if (c >= "0" && c <= "9") begin
         r = {1'b1, 4'(c - "0")};
      end else if (hex && c >= "a" && c <= "f") begin
         r = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (hex && c >= "A" && c <= "F") begin
         r = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return r;
   endfunction

   // e[0] is '#'; len is the entity body length
   // A nonzero digit with three (two in hex) digits after it pushes the value past 127,
   // so only the last three (two) digits of the run are ever weighed.
   function automatic logic [7:0] numeric_char(input ent_buf_type e, input logic [3:0] len);
      logic                       hex;
      logic                       neg;
      logic                       found;
      logic                       big;
      logic                       inrun;
      logic [3:0]                 p;
      logic [4:0]                 d;
      logic [EBUF_DEPTH-1:0]      run;
      logic [EBUF_DEPTH-1:0][3:0] dv;
      logic [3:0]                 c0, c1, c2;
      logic [9:0]                 mag;
      hex   = (len > 4'd1) && (e[1] == "x");
      p     = len;
      found = 1'b0;
      for (int q = 1; q < ENTITY_SPAN; q++) begin
         if (!found && (!hex || q >= 2) && (4'(q) >= len || !is_space(e[q]))) begin
            found = 1'b1;
            p     = 4'(q);
         end
      end
      neg = 1'b0;
      if (p < len && (e[p] == "+" || e[p] == "-")) begin
         neg = (e[p] == "-");
         p   = p + 4'd1;
      end
      if (hex && ({1'b0, p} + 5'd1) < {1'b0, len} && e[p] == "0" &&
          (e[p + 4'd1] == "x" || e[p + 4'd1] == "X")) begin
         p = p + 4'd2;
      end
      inrun = 1'b0;
      run   = '0;
      dv    = '0;
      for (int q = 1; q < ENTITY_SPAN; q++) begin
         d     = digit_of(e[q], hex);
         dv[q] = d[3:0];
         if (4'(q) == p) begin
            inrun = 1'b1;
         end
         inrun  = inrun && d[4] && (4'(q) < len);
         run[q] = inrun;
      end
      big = 1'b0;
      c0  = '0;
      c1  = '0;
      c2  = '0;
      for (int q = 1; q < ENTITY_SPAN; q++) begin
         if (run[q] && dv[q] != 4'd0 && (hex ? run[q + 2] : run[q + 3])) begin
            big = 1'b1;
         end
         if (run[q] && !run[q + 1]) begin
            c0 = dv[q];
            c1 = run[q - 1] ? dv[q - 1] : 4'd0;
            c2 = run[(q > 1) ? q - 2 : 0] ? dv[(q > 1) ? q - 2 : 0] : 4'd0;
         end
      end
      if (hex) begin
         mag = {2'b00, c1, c0};
      end else begin
         mag = 10'(c2) * 10'd100 + 10'(c1) * 10'd10 + 10'(c0);
      end
      return (!neg && !big && mag >= 10'd1 && mag <= 10'd127) ? mag[7:0] : CHAR_QMARK;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/html_strip_entity_decode_top.sv */
// HTML tag stripper and entity decoder with newline run limiting.
//
// Takes one markup byte per cycle on req unless req_stall is raised, and gives decoded bytes
// on rsp. Bytes sit in an 11-byte lookahead window, so output trails input by ten bytes; a
// byte at the head is decided once the window is full or in_last has been taken. Each cycle
// moves at most one result beat, so the sustained rate is one byte per cycle while rsp_stall
// stays low; an unknown entity is re-sent byte by byte from the window while input keeps
// flowing. On a beat with in_last set, input is held off while the window drains, and then a
// closing beat carries out_last (a bare end beat with out_has_byte low if the final beat of
// text produced nothing). The newline run limit sits at byte address 0.
`default_nettype none
module html_strip_entity_decode_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hsed_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hsed_pkg::rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

`include "html_strip_entity_decode_top_macros.svh"

   localparam int unsigned W  = hsed_pkg::WIN_DEPTH;
   localparam int unsigned FW = hsed_pkg::FILL_W;

   logic [7:0]    win_ff [W];
   logic [7:0]    win_in [W];
   logic [FW-1:0] fill_ff, fill_in;
   logic          in_tag_ff, in_tag_in;
   logic          empty_ff, empty_in;
   logic          ends_nl_ff, ends_nl_in;
   logic [3:0]    run_ff, run_in;
   logic [3:0]    limit_ff, limit_in;
   logic [FW-1:0] lit_cnt_ff, lit_cnt_in;
   logic          lit_final_ff, lit_final_in;
   logic          last_seen_ff, last_seen_in;
   logic          hold_v_ff, hold_v_in;
   logic [7:0]    hold_ff, hold_in;
   logic          rsp_valid_ff, rsp_valid_in;
   hsed_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          out_free, interp, go, finish, accept;
   logic [FW-1:0] consume_n, fill_mid;
   logic [7:0]    head;
   logic [7:0]    lw1, lw2, lw3;
   logic          block_tag;
   logic          semi_found;
   logic [FW-1:0] semi_pos;
   logic [3:0]    elen;
   hsed_pkg::ent_buf_type ebuf;
   logic          raw_req, put, fin_tag;
   logic [7:0]    raw_byte;
   logic          push_v;
   hsed_pkg::rsp_type push_d;
   logic          csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == hsed_pkg::CSR_IDX_NL_LIMIT) ? {28'd0, limit_ff} : '0;
   assign limit_in   = (csr_wr && csr_paddr[2] == hsed_pkg::CSR_IDX_NL_LIMIT) ?
                       csr_pwdata[3:0] : limit_ff;

   assign head = win_ff[0];
   assign lw1  = hsed_pkg::lower_char(win_ff[1]);
   assign lw2  = hsed_pkg::lower_char(win_ff[2]);
   assign lw3  = hsed_pkg::lower_char(win_ff[3]);

   always_comb begin
      block_tag = (fill_ff >= FW'(2) && lw1 == "p") ||
                  (fill_ff >= FW'(4) && lw1 == "d" && lw2 == "i" && lw3 == "v") ||
                  (fill_ff >= FW'(3) && ((lw1 == "b" && lw2 == "r") ||
                                         (lw1 == "h" && (lw2 == "1" || lw2 == "2" ||
                                                         lw2 == "3")) ||
                                         (lw1 == "l" && lw2 == "i") ||
                                         (lw1 == "t" && lw2 == "r")));
      semi_found = 1'b0;
      semi_pos   = '0;
      for (int s = 1; s <= hsed_pkg::ENTITY_SPAN; s++) begin
         if (!semi_found && FW'(s) < fill_ff && win_ff[s] == ";") begin
            semi_found = 1'b1;
            semi_pos   = FW'(s);
         end
      end
      elen = 4'(semi_pos - FW'(1));
      ebuf = '0;
      for (int k = 0; k < hsed_pkg::ENTITY_SPAN; k++) begin
         ebuf[k] = win_ff[k + 1];
      end
   end

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      interp   = (lit_cnt_ff == '0) &&
                 (fill_ff == FW'(W) || (last_seen_ff && fill_ff != '0));
      go       = out_free && (lit_cnt_ff != '0 || interp);
      finish   = out_free && last_seen_ff && fill_ff == '0 && lit_cnt_ff == '0;

      raw_req      = 1'b0;
      raw_byte     = head;
      consume_n    = '0;
      in_tag_in    = in_tag_ff;
      lit_cnt_in   = lit_cnt_ff;
      lit_final_in = lit_final_ff;
      fin_tag      = last_seen_ff;

      if (go) begin
         if (lit_cnt_ff != '0) begin
            raw_req    = 1'b1;
            consume_n  = FW'(1);
            lit_cnt_in = lit_cnt_ff - FW'(1);
            fin_tag    = lit_final_ff;
         end else if (head == "<") begin
            in_tag_in = 1'b1;
            consume_n = FW'(1);
            if (block_tag && !empty_ff && !ends_nl_ff) begin
               raw_req  = 1'b1;
               raw_byte = hsed_pkg::CHAR_LF;
            end
         end else if (in_tag_ff) begin
            consume_n = FW'(1);
            if (head == ">") begin
               in_tag_in = 1'b0;
            end
         end else if (head == "&" && semi_found) begin
            consume_n = semi_pos + FW'(1);
            raw_req   = 1'b1;
            if (elen == 4'd3 && {ebuf[0], ebuf[1], ebuf[2]} == "amp") begin
               raw_byte = "&";
            end else if (elen == 4'd2 && {ebuf[0], ebuf[1]} == "lt") begin
               raw_byte = "<";
            end else if (elen == 4'd2 && {ebuf[0], ebuf[1]} == "gt") begin
               raw_byte = ">";
            end else if (elen == 4'd4 && {ebuf[0], ebuf[1], ebuf[2], ebuf[3]} == "quot") begin
               raw_byte = "\"";
            end else if (elen == 4'd4 && {ebuf[0], ebuf[1], ebuf[2], ebuf[3]} == "apos") begin
               raw_byte = "'";
            end else if (elen == 4'd4 && ({ebuf[0], ebuf[1], ebuf[2], ebuf[3]} == "nbsp" ||
                                          {ebuf[0], ebuf[1], ebuf[2], ebuf[3]} == "#160")) begin
               raw_byte = hsed_pkg::CHAR_SPACE;
            end else if (elen >= 4'd1 && ebuf[0] == "#") begin
               raw_byte = hsed_pkg::numeric_char(ebuf, elen);
            end else begin
               // unknown entity: '&' goes out now, the rest through ';' follows verbatim
               consume_n    = FW'(1);
               lit_cnt_in   = semi_pos;
               lit_final_in = last_seen_ff;
            end
         end else begin
            raw_req   = 1'b1;
            consume_n = FW'(1);
         end
      end

      empty_in   = empty_ff;
      ends_nl_in = ends_nl_ff;
      run_in     = run_ff;
      put        = 1'b0;
      if (raw_req) begin
         empty_in   = 1'b0;
         ends_nl_in = (raw_byte == hsed_pkg::CHAR_LF);
         if (raw_byte == hsed_pkg::CHAR_LF) begin
            put    = (run_ff < limit_ff);
            run_in = (run_ff == hsed_pkg::RUN_MAX) ? run_ff : run_ff + 4'd1;
         end else begin
            put    = 1'b1;
            run_in = '0;
         end
      end

      push_v       = 1'b0;
      push_d       = '0;
      hold_in      = hold_ff;
      hold_v_in    = hold_v_ff;
      last_seen_in = last_seen_ff;
      if (put && !fin_tag) begin
         push_v = 1'b1;
         push_d = '{out_byte: raw_byte, out_has_byte: 1'b1, out_last: 1'b0};
      end else if (put) begin
         // keep one beat back so the end marker can ride on it
         push_v    = hold_v_ff;
         push_d    = '{out_byte: hold_ff, out_has_byte: 1'b1, out_last: 1'b0};
         hold_in   = raw_byte;
         hold_v_in = 1'b1;
      end
      if (finish) begin
         push_v = 1'b1;
         push_d = hold_v_ff ? '{out_byte: hold_ff, out_has_byte: 1'b1, out_last: 1'b1}
                            : '{out_byte: 8'd0, out_has_byte: 1'b0, out_last: 1'b1};
         hold_v_in    = 1'b0;
         last_seen_in = 1'b0;
         in_tag_in    = 1'b0;
         empty_in     = 1'b1;
         ends_nl_in   = 1'b0;
         run_in       = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = push_v;
         rsp_data_in  = push_d;
      end

      req_stall = last_seen_ff || (fill_ff == FW'(W) && consume_n == '0);
      accept    = req_valid && !req_stall;
      fill_mid  = fill_ff - consume_n;
      for (int i = 0; i < W; i++) begin
         win_in[i] = win_ff[i];
         for (int j = i; j < W; j++) begin
            if (FW'(j - i) == consume_n) begin
               win_in[i] = win_ff[j];
            end
         end
         if (accept && fill_mid == FW'(i)) begin
            win_in[i] = req_data.in_byte;
         end
      end
      fill_in = fill_mid + FW'(accept);
      if (accept && req_data.in_last) begin
         last_seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         in_tag_ff    <= 1'b0;
         empty_ff     <= 1'b1;
         ends_nl_ff   <= 1'b0;
         run_ff       <= '0;
         limit_ff     <= hsed_pkg::NL_LIMIT_RESET;
         lit_cnt_ff   <= '0;
         lit_final_ff <= 1'b0;
         last_seen_ff <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         in_tag_ff    <= in_tag_in;
         empty_ff     <= empty_in;
         ends_nl_ff   <= ends_nl_in;
         run_ff       <= run_in;
         limit_ff     <= limit_in;
         lit_cnt_ff   <= lit_cnt_in;
         lit_final_ff <= lit_final_in;
         last_seen_ff <= last_seen_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HSED_ASSERT_NOW(a_lit_in_window, lit_cnt_ff != '0, lit_cnt_ff <= fill_ff, "literal run beyond window")
   `HSED_ASSERT_NOW(a_hold_final, hold_v_ff, last_seen_ff, "held beat outside final flush")
   `HSED_ASSERT_NOW(a_bare_is_last, rsp_valid_ff && !rsp_data_ff.out_has_byte, rsp_data_ff.out_last, "bare beat without last")
   `HSED_ASSERT_NEXT(a_last_flush, req_valid && !req_stall && req_data.in_last, last_seen_ff, "last beat did not start flush")

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for html_strip_entity_decode_top: directed and random markup texts checked against a predictor.
`default_nettype none

class hsed_scoreboard;
   byte unsigned           win[11];
   int                     fill;
   bit                     in_tag;
   bit                     out_empty;
   bit                     ends_nl;
   int                     nl_run;
   int                     nl_limit;
   int                     beat_cnt;
   int                     errors;
   hsed_pkg::rsp_type      exp_q[$];

   function new();
      nl_limit = 2;
      errors   = 0;
      clear();
   endfunction

   function void clear();
      fill      = 0;
      in_tag    = 0;
      out_empty = 1;
      ends_nl   = 0;
      nl_run    = 0;
   endfunction

   function void put(byte unsigned b);
      hsed_pkg::rsp_type r;
      if (beat_cnt >= 12) return;
      r.out_byte     = b;
      r.out_has_byte = 1'b1;
      r.out_last     = 1'b0;
      exp_q = {exp_q, r};
      beat_cnt++;
   endfunction

   function void emit(byte unsigned b);
      out_empty = 0;
      ends_nl   = (b == 8'h0A);
      if (b == 8'h0A) begin
         if (nl_run < nl_limit) put(b);
         if (nl_run < 15) nl_run++;
      end else begin
         nl_run = 0;
         put(b);
      end
   endfunction

   function bit tag_is(string s);
      byte unsigned c;
      if (fill < s.len() + 1) return 0;
      for (int k = 0; k < s.len(); k++) begin
         c = win[1 + k];
         if (c >= "A" && c <= "Z") c = c + 32;
         if (c != s[k]) return 0;
      end
      return 1;
   endfunction

   function bit ent_is(int len, string s);
      if (len != s.len()) return 0;
      for (int k = 0; k < len; k++) if (win[1 + k] != s[k]) return 0;
      return 1;
   endfunction

   function int digit(byte unsigned c, int base);
      int d;
      d = -1;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (c >= "a" && c <= "f") d = c - "a" + 10;
      else if (c >= "A" && c <= "F") d = c - "A" + 10;
      if (d >= base) d = -1;
      return d;
   endfunction

   function void decode_number(int len);
      int p, base, mag, d;
      bit neg;
      p = 1; base = 10; mag = 0; neg = 0;
      if (len > 1 && win[2] == "x") begin
         base = 16; p = 2;
      end
      while (p < len && (win[1 + p] == " " || (win[1 + p] >= 9 && win[1 + p] <= 13))) p++;
      if (p < len && (win[1 + p] == "+" || win[1 + p] == "-")) begin
         neg = (win[1 + p] == "-"); p++;
      end
      if (base == 16 && p + 1 < len && win[1 + p] == "0" &&
          (win[2 + p] == "x" || win[2 + p] == "X")) p += 2;
      while (p < len) begin
         d = digit(win[1 + p], base);
         if (d < 0) break;
         mag = mag * base + d;
         if (mag > 1000) mag = 1000;
         p++;
      end
      if (!neg && mag >= 1 && mag <= 127) emit(mag[7:0]);
      else emit(hsed_pkg::CHAR_QMARK);
   endfunction

   function void decode_entity(int len);
      if (ent_is(len, "amp")) emit("&");
      else if (ent_is(len, "lt")) emit("<");
      else if (ent_is(len, "gt")) emit(">");
      else if (ent_is(len, "quot")) emit(8'h22);
      else if (ent_is(len, "apos")) emit(8'h27);
      else if (ent_is(len, "nbsp") || ent_is(len, "#160")) emit(hsed_pkg::CHAR_SPACE);
      else if (len >= 1 && win[1] == "#") decode_number(len);
      else begin
         emit("&");
         for (int k = 0; k < len; k++) emit(win[1 + k]);
         emit(";");
      end
   endfunction

   function int head();
      byte unsigned c;
      c = win[0];
      if (c == "<") begin
         in_tag = 1;
         if (tag_is("p") || tag_is("div") || tag_is("br") || tag_is("h1") ||
             tag_is("h2") || tag_is("h3") || tag_is("li") || tag_is("tr")) begin
            if (!out_empty && !ends_nl) emit(8'h0A);
         end
         return 1;
      end
      if (in_tag) begin
         if (c == ">") in_tag = 0;
         return 1;
      end
      if (c == "&") begin
         for (int s = 1; s < fill && s <= 10; s++) begin
            if (win[s] == ";") begin
               decode_entity(s - 1);
               return s + 1;
            end
         end
      end
      emit(c);
      return 1;
   endfunction

   function void consume(int n);
      if (n > fill) n = fill;
      for (int k = 0; k + n < fill; k++) win[k] = win[k + n];
      fill -= n;
   endfunction

   function void note_input(hsed_pkg::req_type r);
      hsed_pkg::rsp_type e;
      beat_cnt = 0;
      if (fill < 11) begin
         win[fill] = r.in_byte;
         fill++;
      end
      if (fill >= 11) consume(head());
      if (r.in_last) begin
         while (fill > 0) consume(head());
         if (beat_cnt == 0) begin
            e.out_byte = 0; e.out_has_byte = 0; e.out_last = 1;
            exp_q = {exp_q, e};
         end else begin
            exp_q[$].out_last = 1'b1;
         end
         clear();
      end
   endfunction

   function void check_beat(hsed_pkg::rsp_type a);
      hsed_pkg::rsp_type e;
      if (exp_q.size() == 0) begin
         $display("%0t: unexpected beat %h", $realtime, a);
         errors++;
         return;
      end
      e = exp_q.pop_front();
      if (a.out_byte !== e.out_byte) begin
         $display("%0t: out_byte exp %h got %h", $realtime, e.out_byte, a.out_byte);
         errors++;
      end
      if (a.out_has_byte !== e.out_has_byte) begin
         $display("%0t: out_has_byte exp %b got %b", $realtime, e.out_has_byte, a.out_has_byte);
         errors++;
      end
      if (a.out_last !== e.out_last) begin
         $display("%0t: out_last exp %b got %b", $realtime, e.out_last, a.out_last);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   hsed_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   hsed_pkg::rsp_type rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   hsed_scoreboard    sb;
   bit                calm;
   int                hold;
   int                idle_cycles;
   int                sent;
   byte unsigned      text[$];

   localparam int CSR_ADDR = 4 * int'(hsed_pkg::CSR_IDX_NL_LIMIT);

   html_strip_entity_decode_top u_top (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_beat(rsp_data);
         hold = calm ? 0 : $urandom_range(0, 10);
      end
   end

   always @(negedge clock) begin
      rsp_stall = (hold > 0);
      if (hold > 0) hold--;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles > 3000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send_byte(input byte unsigned b, input bit last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1;
      req_data.in_byte = b;
      req_data.in_last = last;
      do @(posedge clock); while (req_stall);
      sb.note_input(req_data);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
      text.delete();
   endtask

   task automatic drain();
      req_valid = 0;
      while (sb.exp_q.size() != 0) @(negedge clock);
      repeat (15) @(negedge clock);
   endtask

   task automatic write_limit(input int v);
      csr_psel    = 1;
      csr_pwrite  = 1;
      csr_paddr   = 3'(CSR_ADDR);
      csr_pwdata  = v;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      sb.nl_limit = v & 15;
   endtask

   function automatic void add(string s);
      for (int k = 0; k < s.len(); k++) text = {text, s[k]};
   endfunction

   function automatic string mixcase(string s);
      string r;
      r = s;
      for (int k = 0; k < r.len(); k++)
         if (r[k] >= "a" && r[k] <= "z" && $urandom_range(0, 1)) r[k] = r[k] - 32;
      return r;
   endfunction

   function automatic void add_piece();
      string tags[14] = '{"p", "div", "br", "h1", "h2", "h3", "li", "tr",
                          "a", "span", "b", "h4", "d", "t"};
      string ents[9]  = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "#160", "Amp", "nbs"};
      string hexdig   = "0123456789abcdefABCDEF";
      bit hex;
      case ($urandom_range(0, 11))
         0, 1: begin
            add({"<", mixcase(tags[$urandom_range(0, 13)])});
            if ($urandom_range(0, 1)) add(" x=1");
            add(">");
         end
         2: add({"</", mixcase(tags[$urandom_range(0, 13)]), ">"});
         3, 4: add({"&", ents[$urandom_range(0, 8)], ";"});
         5: begin
            hex = $urandom_range(0, 1);
            add(hex ? "&#x" : "&#");
            if ($urandom_range(0, 3) == 0) add(" ");
            case ($urandom_range(0, 3))
               0: add("-");
               1: add("+");
               default: ;
            endcase
            if (hex && $urandom_range(0, 2) == 0) add($urandom_range(0, 1) ? "0x" : "0X");
            repeat ($urandom_range(0, 4))
               text = {text, hex ? 8'(hexdig[$urandom_range(0, 21)])
                                 : 8'("0" + $urandom_range(0, 9))};
            add(";");
         end
         6: begin
            add("&");
            repeat ($urandom_range(0, 11)) text = {text, 8'("a" + $urandom_range(0, 25))};
            if ($urandom_range(0, 1)) add(";");
         end
         7: repeat ($urandom_range(1, 6)) text = {text, 8'h0A};
         8: repeat ($urandom_range(1, 5)) text = {text, 8'("a" + $urandom_range(0, 25))};
         9: repeat ($urandom_range(1, 3)) text = {text, 8'($urandom_range(0, 255))};
         10: add({"<a", mixcase(tags[$urandom_range(0, 7)])});
         default: add(" ");
      endcase
   endfunction

   initial begin
      int limits[6];
      sb          = new();
      hold        = 0;
      calm        = 0;
      sent        = 0;
      idle_cycles = 0;
      reset       = 1;
      req_valid   = 0;
      req_data    = '0;
      rsp_stall   = 0;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: tags, entities, numerics, newline runs, short tail
      add("x<P>&amp;&#x41;&;&zz;\n\n\n<LI><di");
      send_text();
      add("&");
      send_text();
      add("&#-5;&# 66;&#x0x42;&#0;&#999;&lt;&gt;&quot;&apos;&nbsp;&#160;");
      send_text();
      drain();

      limits = '{1, 15, 0, 2, 7, 0};
      limits[5] = $urandom_range(1, 15);
      foreach (limits[i]) begin
         write_limit(limits[i]);
         @(negedge clock);
         while (sent < 80 + 40 * (i + 1)) begin
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 8)) add_piece();
            send_text();
         end
         drain();
      end

      if (sb.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule

`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/hsed_pkg.sv
hw/rtl/html_strip_entity_decode_top.sv
sim/tb.sv
